### hdl/codon_adaptation_index_defines.svh
// Assertion macros used by the checker of the codon adaptation index block.
`ifndef CODON_ADAPTATION_INDEX_DEFINES_SVH
`define CODON_ADAPTATION_INDEX_DEFINES_SVH

// Same-cycle implication, held off while reset is asserted.
`define CAI_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off while reset is asserted.
`define CAI_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/cai_pkg.sv
package cai_pkg;

  localparam int FREQ_BITS  = 24;
  localparam int COUNT_BITS = 20;
  localparam int FRAC_BITS  = 16;

  localparam int CODON_BITS  = 6;
  localparam int CODON_SLOTS = 1 << CODON_BITS;
  localparam int ACID_BITS   = 5;
  localparam int NUM_ACIDS   = 21;
  localparam logic [ACID_BITS-1:0] NO_ACID = ACID_BITS'(NUM_ACIDS);

  // running sum magnitude, saturates at 2^(SUM_BITS-1)
  localparam int SUM_BITS  = 42;
  localparam int POS_BITS  = $clog2(FREQ_BITS);
  localparam int LOG_BITS  = POS_BITS + FRAC_BITS;
  localparam int STEP_BITS = $clog2(SUM_BITS + 1);

  localparam int Q_BITS    = 30;
  localparam int LN2_BITS  = 32;
  localparam int PROD_BITS = Q_BITS + LN2_BITS;
  localparam int OUT_BITS  = 22;

  localparam logic [LN2_BITS-1:0]  LN2_Q32  = 32'd2977044472;
  localparam logic [PROD_BITS-1:0] RND_HALF = PROD_BITS'(1) << (LN2_BITS - 1);
  localparam logic [Q_BITS-1:0]    OUT_MAG  = Q_BITS'(1) << (OUT_BITS - 1);
  localparam logic [SUM_BITS-1:0]  SUM_MAX  = SUM_BITS'(1) << (SUM_BITS - 1);

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_SCORE = 2'd1,
    OP_CLEAR = 2'd2,
    OP_END   = 2'd3
  } cai_op_e;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_EMPTY  = 2'd1,
    ERR_NOACID = 2'd2,
    ERR_ZERO   = 2'd3
  } cai_err_e;

  typedef enum logic [1:0] {
    UOP_HOLD = 2'd0,
    UOP_LOAD = 2'd1,
    UOP_NORM = 2'd2,
    UOP_DIV  = 2'd3
  } cai_uop_e;

  typedef struct packed {
    cai_op_e                opcode;
    logic [CODON_BITS-1:0]  codon_index;
    logic [ACID_BITS-1:0]   acid_index;
    logic [FREQ_BITS-1:0]   frequency;
    logic                   last_codon;
  } cai_req_t;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] log_index;
    logic [COUNT_BITS-1:0]      codon_count;
    cai_err_e                   error_code;
  } cai_res_t;

  typedef struct packed {
    logic load;
    logic clear;
    logic read;
  } cai_tbl_ctl_t;

  typedef struct packed {
    cai_uop_e op;
  } cai_unit_cmd_t;

endpackage

### hdl/codon_adaptation_index.sv
// Codon adaptation index scorer, log-mean form. A request with opcode load
// writes one codon entry (frequency and acid; an acid above 20 is ignored),
// clear empties the table, score adds log2(freq) - log2(max of its acid) to
// the running sum, and end closes a sequence without scoring. When
// last_codon is set on score or end, one result follows: the mean natural
// log weight in signed Q5.16, the codon count and a sticky error code.
// Requests are taken when start_i is high and busy_o is low. The result is
// shown for exactly one cycle with done_o high; the receiver cannot stall
// it, so it must capture the result in that cycle. Load, clear and an end
// without last_codon leave busy_o low. A score keeps busy_o high while the
// shared shift/subtract unit normalizes one bit per cycle for each Mitchell
// log, first the 24-bit frequency and then the acid maximum, each until its
// leading one is found; a codon that cannot be scored, or any codon after an
// error, leaves the lookup without normalizing. Closing a sequence runs
// one setup step, 42 one-bit divide steps of the sum by the count in the
// same unit, one multiply by ln2 and one rounding step; a close with an
// error reports straight from the setup step.
// No clearing pass after reset.
module codon_adaptation_index (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  cai_pkg::cai_req_t req_i,
  output logic              done_o,
  output cai_pkg::cai_res_t res_o
);
  import cai_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOOK  = 3'd1;
  localparam logic [2:0] S_NORMF = 3'd2;
  localparam logic [2:0] S_NORMM = 3'd3;
  localparam logic [2:0] S_CLOSE = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_MUL   = 3'd6;
  localparam logic [2:0] S_RND   = 3'd7;

  logic [2:0]            state_q, state_d;
  logic [COUNT_BITS-1:0] count_q, count_d;
  logic [SUM_BITS-1:0]   mag_q, mag_d;      // magnitude of the (negative) log sum
  cai_err_e              err_q, err_d;
  logic                  last_q, last_d;
  logic                  done_q, done_d;
  cai_res_t              res_q, res_d;
  logic [FREQ_BITS-1:0]  maxv_q, maxv_d;
  logic [LOG_BITS-1:0]   logf_q, logf_d;
  logic [POS_BITS-1:0]   pos_q, pos_d;
  logic [STEP_BITS-1:0]  step_q, step_d;
  logic [PROD_BITS-1:0]  prod_q, prod_d;

  cai_tbl_ctl_t          tctl;
  cai_unit_cmd_t         ucmd;
  logic [SUM_BITS-1:0]   uload;
  logic [SUM_BITS-1:0]   sh;
  logic [ACID_BITS-1:0]  rd_acid;
  logic [FREQ_BITS-1:0]  rd_freq;
  logic [FREQ_BITS-1:0]  rd_max;

  logic                             accept;
  logic [2:0]                       after_score;
  logic [FREQ_BITS+FRAC_BITS-2:0]   frac_ext;
  logic [LOG_BITS-1:0]              log_now;
  logic                             norm_done;
  logic [LOG_BITS:0]                term;
  logic [LOG_BITS-1:0]              term_mag;
  logic [SUM_BITS:0]                sum_ext;
  logic [SUM_BITS-1:0]              sum_sat;
  cai_err_e                         err_fin;
  logic [Q_BITS-1:0]                q_cap;
  logic [PROD_BITS-1:0]             rnd;
  logic [Q_BITS-1:0]                r_full;
  logic [OUT_BITS-1:0]              r_cl;

  cai_table u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (tctl),
    .codon_i   (req_i.codon_index),
    .acid_i    (req_i.acid_index),
    .freq_i    (req_i.frequency),
    .rd_acid_o (rd_acid),
    .rd_freq_o (rd_freq),
    .rd_max_o  (rd_max)
  );

  cai_unit u_unit (
    .clk_i  (clk_i),
    .cmd_i  (ucmd),
    .load_i (uload),
    .div_i  (count_q),
    .sh_o   (sh)
  );

  assign accept      = start_i && (state_q == S_IDLE);
  assign after_score = last_q ? S_CLOSE : S_IDLE;

  // Mitchell log: leading-one position, then the bits below it, zero padded
  assign frac_ext  = {sh[SUM_BITS-2 -: FREQ_BITS-1], {FRAC_BITS{1'b0}}};
  assign log_now   = {pos_q, frac_ext[FREQ_BITS+FRAC_BITS-2 -: FRAC_BITS]};
  assign norm_done = sh[SUM_BITS-1] || (pos_q == '0);

  // term = log(max) - log(freq), the magnitude of the codon's log weight; a negative term is clamped to zero
  assign term     = {1'b0, log_now} - {1'b0, logf_q};
  assign term_mag = term[LOG_BITS] ? '0 : term[LOG_BITS-1:0];
  assign sum_ext  = {1'b0, mag_q} + (SUM_BITS+1)'(term_mag);
  assign sum_sat  = (sum_ext > {1'b0, SUM_MAX}) ? SUM_MAX : sum_ext[SUM_BITS-1:0];

  assign err_fin = ((err_q == ERR_NONE) && (count_q == '0)) ? ERR_EMPTY : err_q;

  // quotient capped to Q_BITS, times ln2 in Q.32, rounded half up
  assign q_cap  = (|sh[SUM_BITS-1:Q_BITS]) ? '1 : sh[Q_BITS-1:0];
  assign rnd    = prod_q + RND_HALF;
  assign r_full = rnd[PROD_BITS-1:LN2_BITS];
  assign r_cl   = (r_full > OUT_MAG) ? OUT_MAG[OUT_BITS-1:0] : r_full[OUT_BITS-1:0];

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    mag_d   = mag_q;
    err_d   = err_q;
    last_d  = last_q;
    done_d  = 1'b0;
    res_d   = res_q;
    maxv_d  = maxv_q;
    logf_d  = logf_q;
    pos_d   = pos_q;
    step_d  = step_q;
    prod_d  = prod_q;
    tctl    = '0;
    ucmd.op = UOP_HOLD;
    uload   = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (req_i.opcode)
            OP_LOAD:  tctl.load  = 1'b1;
            OP_CLEAR: tctl.clear = 1'b1;
            OP_SCORE: begin
              tctl.read = 1'b1;
              last_d    = req_i.last_codon;
              state_d   = S_LOOK;
            end
            OP_END: begin
              if (req_i.last_codon) begin
                state_d = S_CLOSE;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end

      // table entry is in; count the codon and check for errors
      S_LOOK: begin
        if (count_q != '1) begin
          count_d = count_q + COUNT_BITS'(1);
        end
        if (rd_acid >= NO_ACID) begin
          if (err_q == ERR_NONE) err_d = ERR_NOACID;
          state_d = after_score;
        end else if ((rd_freq == '0) || (rd_max == '0)) begin
          if (err_q == ERR_NONE) err_d = ERR_ZERO;
          state_d = after_score;
        end else if (err_q != ERR_NONE) begin
          state_d = after_score;
        end else begin
          ucmd.op = UOP_LOAD;
          uload   = {rd_freq, {(SUM_BITS-FREQ_BITS){1'b0}}};
          maxv_d  = rd_max;
          pos_d   = POS_BITS'(FREQ_BITS - 1);
          state_d = S_NORMF;
        end
      end

      S_NORMF: begin
        if (norm_done) begin
          logf_d  = log_now;
          ucmd.op = UOP_LOAD;
          uload   = {maxv_q, {(SUM_BITS-FREQ_BITS){1'b0}}};
          pos_d   = POS_BITS'(FREQ_BITS - 1);
          state_d = S_NORMM;
        end else begin
          ucmd.op = UOP_NORM;
          pos_d   = pos_q - POS_BITS'(1);
        end
      end

      S_NORMM: begin
        if (norm_done) begin
          mag_d   = sum_sat;
          state_d = after_score;
        end else begin
          ucmd.op = UOP_NORM;
          pos_d   = pos_q - POS_BITS'(1);
        end
      end

      S_CLOSE: begin
        if (err_fin != ERR_NONE) begin
          done_d  = 1'b1;
          res_d   = '{log_index: '0, codon_count: count_q, error_code: err_fin};
          mag_d   = '0;
          count_d = '0;
          err_d   = ERR_NONE;
          state_d = S_IDLE;
        end else begin
          ucmd.op = UOP_LOAD;
          uload   = mag_q;
          step_d  = STEP_BITS'(SUM_BITS);
          state_d = S_DIV;
        end
      end

      S_DIV: begin
        ucmd.op = UOP_DIV;
        step_d  = step_q - STEP_BITS'(1);
        if (step_q == STEP_BITS'(1)) begin
          state_d = S_MUL;
        end
      end

      S_MUL: begin
        prod_d  = PROD_BITS'(q_cap) * PROD_BITS'(LN2_Q32);
        state_d = S_RND;
      end

      S_RND: begin
        done_d  = 1'b1;
        res_d   = '{log_index: $signed(OUT_BITS'(0) - r_cl),
                    codon_count: count_q, error_code: ERR_NONE};
        mag_d   = '0;
        count_d = '0;
        err_d   = ERR_NONE;
        state_d = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      mag_q   <= '0;
      err_q   <= ERR_NONE;
      last_q  <= 1'b0;
      done_q  <= 1'b0;
      pos_q   <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      mag_q   <= mag_d;
      err_q   <= err_d;
      last_q  <= last_d;
      done_q  <= done_d;
      pos_q   <= pos_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    maxv_q <= maxv_d;
    logf_q <= logf_d;
    prod_q <= prod_d;
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

### hdl/cai_table.sv
module cai_table (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cai_pkg::cai_tbl_ctl_t         ctl_i,
  input  logic [cai_pkg::CODON_BITS-1:0] codon_i,
  input  logic [cai_pkg::ACID_BITS-1:0]  acid_i,
  input  logic [cai_pkg::FREQ_BITS-1:0]  freq_i,
  output logic [cai_pkg::ACID_BITS-1:0]  rd_acid_o,
  output logic [cai_pkg::FREQ_BITS-1:0]  rd_freq_o,
  output logic [cai_pkg::FREQ_BITS-1:0]  rd_max_o
);
  import cai_pkg::*;

  typedef struct packed {
    logic [ACID_BITS-1:0] acid;
    logic [FREQ_BITS-1:0] freq;
  } entry_t;

  entry_t                  mem_q [CODON_SLOTS];
  entry_t                  rd_q;
  logic                    rd_valid_q;
  logic [CODON_SLOTS-1:0]  valid_q;
  logic [FREQ_BITS-1:0]    max_q [NUM_ACIDS];
  logic                    load_ok;

  assign load_ok = ctl_i.load && (acid_i < NO_ACID);

  always_ff @(posedge clk_i) begin
    if (load_ok) begin
      mem_q[codon_i] <= '{acid: acid_i, freq: freq_i};
    end
    if (ctl_i.read) begin
      rd_q <= mem_q[codon_i];
    end
  end

  // valid bits stand in for the cleared table contents
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (ctl_i.clear) begin
        valid_q <= '0;
      end else if (load_ok) begin
        valid_q[codon_i] <= 1'b1;
      end
      if (ctl_i.read) begin
        rd_valid_q <= valid_q[codon_i];
      end
    end
  end

  // per-acid maximum only grows until a clear
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_ACIDS; i++) begin
        max_q[i] <= '0;
      end
    end else if (ctl_i.clear) begin
      for (int i = 0; i < NUM_ACIDS; i++) begin
        max_q[i] <= '0;
      end
    end else if (load_ok && (freq_i > max_q[acid_i])) begin
      max_q[acid_i] <= freq_i;
    end
  end

  assign rd_acid_o = rd_valid_q ? rd_q.acid : NO_ACID;
  assign rd_freq_o = rd_valid_q ? rd_q.freq : '0;
  assign rd_max_o  = (rd_acid_o < NO_ACID) ? max_q[rd_acid_o] : '0;

endmodule

### hdl/cai_unit.sv
module cai_unit (
  input  logic                           clk_i,
  input  cai_pkg::cai_unit_cmd_t         cmd_i,
  input  logic [cai_pkg::SUM_BITS-1:0]   load_i,
  input  logic [cai_pkg::COUNT_BITS-1:0] div_i,
  output logic [cai_pkg::SUM_BITS-1:0]   sh_o
);
  import cai_pkg::*;

  logic [SUM_BITS-1:0]   sh_q, sh_d;
  logic [COUNT_BITS-1:0] rem_q, rem_d;
  logic [COUNT_BITS:0]   shifted;
  logic [COUNT_BITS+1:0] trial;
  logic                  ge;

  // restoring divide step: partial remainder takes the next dividend bit
  assign shifted = {rem_q, sh_q[SUM_BITS-1]};
  assign trial   = {1'b0, shifted} - {2'b00, div_i};
  assign ge      = !trial[COUNT_BITS+1];

  always_comb begin
    sh_d  = sh_q;
    rem_d = rem_q;
    case (cmd_i.op)
      UOP_LOAD: begin
        sh_d  = load_i;
        rem_d = '0;
      end
      UOP_NORM: begin
        sh_d = {sh_q[SUM_BITS-2:0], 1'b0};
      end
      UOP_DIV: begin
        sh_d  = {sh_q[SUM_BITS-2:0], ge};
        rem_d = ge ? trial[COUNT_BITS-1:0] : shifted[COUNT_BITS-1:0];
      end
      default: begin
        sh_d  = sh_q;
        rem_d = rem_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    rem_q <= rem_d;
  end

  assign sh_o = sh_q;

endmodule

### hdl/cai_check.sv
`include "codon_adaptation_index_defines.svh"

module cai_check (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input logic              busy_i,
  input cai_pkg::cai_req_t req_i,
  input logic              done_i,
  input cai_pkg::cai_res_t res_i
);
  import cai_pkg::*;

  logic take_score;
  logic take_table;

  assign take_score = start_i && !busy_i && (req_i.opcode == OP_SCORE);
  assign take_table = start_i && !busy_i &&
                      ((req_i.opcode == OP_LOAD) || (req_i.opcode == OP_CLEAR));

  `CAI_ASSERT_NEXT(a_score_busy, clk_i, rst_ni, take_score, busy_i, "score not busy")
  `CAI_ASSERT_NEXT(a_table_quick, clk_i, rst_ni, take_table, !busy_i && !done_i, "table op slow")
  `CAI_ASSERT_NEXT(a_done_pulse, clk_i, rst_ni, done_i, !done_i, "result strobe repeated")
  `CAI_ASSERT_IMPL(a_err_zero, clk_i, rst_ni, done_i && res_i.error_code != ERR_NONE, res_i.log_index == '0, "error result nonzero")
  `CAI_ASSERT_IMPL(a_empty_cnt, clk_i, rst_ni, done_i && res_i.error_code == ERR_EMPTY, res_i.codon_count == '0, "empty with count")

endmodule

bind codon_adaptation_index cai_check u_cai_check (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_i  (busy_o),
  .req_i   (req_i),
  .done_i  (done_o),
  .res_i   (res_o)
);
